[hw/rtl/lens_distortion_point_map_macros.svh]
// assertion helpers for the rtl
`ifndef LENS_DISTORTION_POINT_MAP_MACROS_SVH
`define LENS_DISTORTION_POINT_MAP_MACROS_SVH

// same-cycle implication
`define LDM_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ldm assertion failed");

// next-cycle implication
`define LDM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ldm assertion failed");

`endif

[hw/rtl/ldm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ldm_pkg;

   localparam int FRAC_BITS = 24;
   localparam logic signed [63:0] SAT_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] ONE_Q = 64'sd16777216;

   // numerator of the normalising division: 33 bit magnitude shifted by the fraction
   localparam int DIV_NUM_BITS = 33 + FRAC_BITS;
   // difference, magnitude, numerator, one stage per quotient bit, sign fix
   localparam int DIV_LAT = DIV_NUM_BITS + 4;
   localparam int MUL_LAT = 5;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam logic [31:0] FOCAL_RESET = 32'h0001_0000;

   typedef struct packed {
      logic                ov;
      logic signed [63:0]  val;
   } qval_type;

   typedef enum logic [2:0] {
      REG_FOCAL_X    = 3'd0,
      REG_FOCAL_Y    = 3'd1,
      REG_CENTER_X   = 3'd2,
      REG_CENTER_Y   = 3'd3,
      REG_RADIAL_K1  = 3'd4,
      REG_RADIAL_K2  = 3'd5,
      REG_RADIAL_K3  = 3'd6,
      REG_TANGENTIAL = 3'd7
   } csr_reg_type;

   // add with clamp to the internal range
   function automatic qval_type sat_add(input logic signed [63:0] a,
                                        input logic signed [63:0] b);
      logic signed [64:0] s;
      qval_type r;
      s = 65'(a) + 65'(b);
      if (s > 65'(SAT_LIM)) begin
         r.ov  = 1'b1;
         r.val = SAT_LIM;
      end else if (s < -65'(SAT_LIM)) begin
         r.ov  = 1'b1;
         r.val = -SAT_LIM;
      end else begin
         r.ov  = 1'b0;
         r.val = s[63:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/ldm_delay.sv]
`timescale 1ns / 1ps
`default_nettype none

module ldm_delay #(
   parameter int DEPTH = 1,
   parameter int WIDTH = 64
) (
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire logic [WIDTH-1:0] din,
   output logic      [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (enable) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

`default_nettype wire

[hw/rtl/ldm_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// (point - center) * 2^24 / focal, rounded, one quotient bit per stage
module ldm_div (
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire logic signed [31:0] point,
   input  wire logic signed [31:0] center,
   input  wire logic [31:0]        focal,
   output logic signed [63:0]      quot
);

   localparam int NB = ldm_pkg::DIV_NUM_BITS;

   logic signed [32:0] diff_ff;
   logic [32:0]        mag_ff;
   logic [NB+1:0]      sgn_ff;
   logic [31:0]        rem_ff [0:NB];
   logic [NB-1:0]      num_ff [0:NB];
   logic [31:0]        rem_in [1:NB];
   logic [NB-1:0]      num_in [1:NB];
   logic signed [63:0] quot_ff;

   always_comb begin
      logic [32:0] trial;
      logic        ge;
      for (int k = 1; k <= NB; k++) begin
         trial = {rem_ff[k-1], num_ff[k-1][NB-1]};
         ge = (trial >= {1'b0, focal});
         rem_in[k] = ge ? 32'(trial - {1'b0, focal}) : trial[31:0];
         num_in[k] = {num_ff[k-1][NB-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         diff_ff   <= 33'(point) - 33'(center);
         mag_ff    <= diff_ff[32] ? 33'(-diff_ff) : 33'(diff_ff);
         sgn_ff    <= {sgn_ff[NB:0], diff_ff[32]};
         rem_ff[0] <= '0;
         num_ff[0] <= {mag_ff, {ldm_pkg::FRAC_BITS{1'b0}}} + NB'(focal >> 1);
         for (int k = 1; k <= NB; k++) begin
            rem_ff[k] <= rem_in[k];
            num_ff[k] <= num_in[k];
         end
         quot_ff <= sgn_ff[NB+1] ? -64'(num_ff[NB]) : 64'(num_ff[NB]);
      end
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

[hw/rtl/ldm_mulq.sv]
`timescale 1ns / 1ps
`default_nettype none

// round(a*b / 2^24) with clamp, four 32x32 partial products
module ldm_mulq (
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire logic signed [63:0] a,
   input  wire logic signed [63:0] b,
   output ldm_pkg::qval_type       res
);

   localparam logic [64:0] ROUND = 65'(1) << (ldm_pkg::FRAC_BITS - 1);

   logic [3:0]  neg_ff;
   logic [63:0] ua_ff, ub_ff;
   logic [63:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [33:0] mid_ff;
   logic [31:0] lo0_ff;
   logic [63:0] hip_ff;
   logic [63:0] hi_ff;
   logic [39:0] lo2_ff;
   logic [64:0] lo_sum;
   logic        ov;
   logic [63:0] mag;
   ldm_pkg::qval_type res_ff;

   always_comb begin
      lo_sum = {1'b0, mid_ff[31:0], lo0_ff} + ROUND;
      ov     = |hi_ff[63:22];
      mag    = ov ? 64'(ldm_pkg::SAT_LIM) : {2'b00, hi_ff[21:0], lo2_ff};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         // magnitudes
         neg_ff <= {neg_ff[2:0], a[63] ^ b[63]};
         ua_ff  <= a[63] ? 64'(-a) : 64'(a);
         ub_ff  <= b[63] ? 64'(-b) : 64'(b);
         // partial products
         p00_ff <= 64'(ua_ff[31:0])  * 64'(ub_ff[31:0]);
         p01_ff <= 64'(ua_ff[31:0])  * 64'(ub_ff[63:32]);
         p10_ff <= 64'(ua_ff[63:32]) * 64'(ub_ff[31:0]);
         p11_ff <= 64'(ua_ff[63:32]) * 64'(ub_ff[63:32]);
         // column sums
         mid_ff <= 34'(p00_ff[63:32]) + 34'(p01_ff[31:0]) + 34'(p10_ff[31:0]);
         lo0_ff <= p00_ff[31:0];
         hip_ff <= p11_ff + 64'(p01_ff[63:32]) + 64'(p10_ff[63:32]);
         // rounding carry into the high word
         hi_ff  <= hip_ff + 64'(mid_ff[33:32]) + 64'(lo_sum[64]);
         lo2_ff <= lo_sum[63:24];
         // clamp and sign
         res_ff.ov  <= ov;
         res_ff.val <= neg_ff[3] ? -mag : mag;
      end
   end

   assign res = res_ff;

endmodule

`default_nettype wire

[hw/rtl/lens_distortion_point_map.sv]
// lens_distortion_point_map: brown-conrady radial and tangential distortion of a point
//
// request channel: req_valid / req_stall with req_point_x, req_point_y (signed q15.16)
// response channel: rsp_valid / rsp_stall with rsp_warped_x, rsp_warped_y (signed
// q15.16, saturated) and rsp_overflow. a transfer happens on a clock edge with valid
// high and stall low. one response per request, in request order.
// configuration: apb-style csr port, 64 bit data, register i at byte address 8*i;
// user rule: only written while no request is in flight; the block does not enforce it.
// path from request to response: the bit-serial-per-stage normalising divider, the
// chain of five-stage q24 multipliers and clamped adds, then the output register.
// throughput: one request per cycle while req_stall is low, set by the fully
// pipelined divider and multipliers.
// reset (synchronous, active high) clears all valid bits, empties the output and skid
// registers and loads the register defaults (focal 1.0, everything else zero).
// when the receiver stalls the output register holds; one more response lands in the
// skid register, after which req_stall rises and the whole pipeline freezes in place.
`timescale 1ns / 1ps
`default_nettype none
`include "lens_distortion_point_map_macros.svh"

module lens_distortion_point_map (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic signed [31:0]              req_point_x,
   input  wire logic signed [31:0]              req_point_y,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [31:0]                   rsp_warped_x,
   output logic signed [31:0]                   rsp_warped_y,
   output logic                                 rsp_overflow,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [ldm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [ldm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ldm_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   // pipeline length from accept to the final clamp register
   localparam int VLEN = ldm_pkg::DIV_LAT + 35;

   // ---------------------------------------------------------------- registers
   logic [31:0]        focal_x_ff, focal_y_ff;
   logic signed [31:0] center_x_ff, center_y_ff;
   logic signed [31:0] k1_ff, k2_ff, k3_ff;
   logic [63:0]        tan_ff;
   ldm_pkg::csr_reg_type csr_idx;

   assign csr_idx    = ldm_pkg::csr_reg_type'(csr_paddr[5:3]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= ldm_pkg::FOCAL_RESET;
         focal_y_ff  <= ldm_pkg::FOCAL_RESET;
         center_x_ff <= '0;
         center_y_ff <= '0;
         k1_ff       <= '0;
         k2_ff       <= '0;
         k3_ff       <= '0;
         tan_ff      <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_idx)
            ldm_pkg::REG_FOCAL_X:    focal_x_ff  <= csr_pwdata[31:0];
            ldm_pkg::REG_FOCAL_Y:    focal_y_ff  <= csr_pwdata[31:0];
            ldm_pkg::REG_CENTER_X:   center_x_ff <= csr_pwdata[31:0];
            ldm_pkg::REG_CENTER_Y:   center_y_ff <= csr_pwdata[31:0];
            ldm_pkg::REG_RADIAL_K1:  k1_ff       <= csr_pwdata[31:0];
            ldm_pkg::REG_RADIAL_K2:  k2_ff       <= csr_pwdata[31:0];
            ldm_pkg::REG_RADIAL_K3:  k3_ff       <= csr_pwdata[31:0];
            ldm_pkg::REG_TANGENTIAL: tan_ff      <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         ldm_pkg::REG_FOCAL_X:    csr_prdata = 64'(focal_x_ff);
         ldm_pkg::REG_FOCAL_Y:    csr_prdata = 64'(focal_y_ff);
         ldm_pkg::REG_CENTER_X:   csr_prdata = {32'd0, center_x_ff};
         ldm_pkg::REG_CENTER_Y:   csr_prdata = {32'd0, center_y_ff};
         ldm_pkg::REG_RADIAL_K1:  csr_prdata = {32'd0, k1_ff};
         ldm_pkg::REG_RADIAL_K2:  csr_prdata = {32'd0, k2_ff};
         ldm_pkg::REG_RADIAL_K3:  csr_prdata = {32'd0, k3_ff};
         ldm_pkg::REG_TANGENTIAL: csr_prdata = tan_ff;
         default:                 csr_prdata = '0;
      endcase
   end

   // a zero focal is used as one lsb
   logic [31:0]        fx_eff, fy_eff;
   logic signed [63:0] fx64, fy64, k1_64, k2_64, k3_64, p1_64, p2_64;

   assign fx_eff = (focal_x_ff == '0) ? 32'd1 : focal_x_ff;
   assign fy_eff = (focal_y_ff == '0) ? 32'd1 : focal_y_ff;
   assign fx64   = $signed({32'd0, fx_eff});
   assign fy64   = $signed({32'd0, fy_eff});
   assign k1_64  = 64'(k1_ff);
   assign k2_64  = 64'(k2_ff);
   assign k3_64  = 64'(k3_ff);
   assign p1_64  = 64'($signed(tan_ff[31:0]));
   assign p2_64  = 64'($signed(tan_ff[63:32]));

   // ---------------------------------------------------------------- flow control
   // global advance; the skid register decouples it from rsp_stall
   logic            en;
   logic [VLEN-1:0] vld_ff;
   logic            skid_vld_ff;

   assign en        = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[VLEN-2:0], req_valid};
      end
   end

   // ---------------------------------------------------------------- normalise (t0)
   logic signed [63:0] x0, y0;

   ldm_div u_div_x (.clock, .enable(en), .point(req_point_x), .center(center_x_ff),
                    .focal(fx_eff), .quot(x0));
   ldm_div u_div_y (.clock, .enable(en), .point(req_point_y), .center(center_y_ff),
                    .focal(fy_eff), .quot(y0));

   // ---------------------------------------------------------------- squares (t5..t7)
   ldm_pkg::qval_type m_x2, m_y2, m_xy;
   ldm_pkg::qval_type s_r2_ff, s_sx_ff, s_sy_ff, s_tsx_ff, s_tsy_ff;

   ldm_mulq u_mul_x2 (.clock, .enable(en), .a(x0), .b(x0), .res(m_x2));
   ldm_mulq u_mul_y2 (.clock, .enable(en), .a(y0), .b(y0), .res(m_y2));
   ldm_mulq u_mul_xy (.clock, .enable(en), .a(x0), .b(y0), .res(m_xy));

   // ---------------------------------------------------------------- tangential (t10..t12)
   ldm_pkg::qval_type m_tx1, m_ty2, m_tx2, m_ty1;
   ldm_pkg::qval_type s_tx1d_ff, s_ty2d_ff;

   ldm_mulq u_mul_tx1 (.clock, .enable(en), .a(p1_64), .b(m_xy.val), .res(m_tx1));
   ldm_mulq u_mul_ty2 (.clock, .enable(en), .a(p2_64), .b(m_xy.val), .res(m_ty2));
   ldm_mulq u_mul_tx2 (.clock, .enable(en), .a(p2_64), .b(s_tsx_ff.val), .res(m_tx2));
   ldm_mulq u_mul_ty1 (.clock, .enable(en), .a(p1_64), .b(s_tsy_ff.val), .res(m_ty1));

   // ---------------------------------------------------------------- radial (t11..t22)
   ldm_pkg::qval_type m_r4, m_k1, m_r6, m_k2, m_k3;
   ldm_pkg::qval_type s_rad1_ff, s_rad2_ff, s_rad_ff;
   logic [63:0]       r2_d5, rad1_d4, rad2_d4;

   ldm_mulq u_mul_r4 (.clock, .enable(en), .a(s_r2_ff.val), .b(s_r2_ff.val), .res(m_r4));
   ldm_mulq u_mul_k1 (.clock, .enable(en), .a(k1_64), .b(s_r2_ff.val), .res(m_k1));
   ldm_delay #(.DEPTH(ldm_pkg::MUL_LAT), .WIDTH(64)) u_dly_r2 (
      .clock, .enable(en), .din(s_r2_ff.val), .dout(r2_d5));
   ldm_mulq u_mul_r6 (.clock, .enable(en), .a(m_r4.val), .b($signed(r2_d5)), .res(m_r6));
   ldm_mulq u_mul_k2 (.clock, .enable(en), .a(k2_64), .b(m_r4.val), .res(m_k2));
   ldm_delay #(.DEPTH(ldm_pkg::MUL_LAT - 1), .WIDTH(64)) u_dly_rad1 (
      .clock, .enable(en), .din(s_rad1_ff.val), .dout(rad1_d4));
   ldm_mulq u_mul_k3 (.clock, .enable(en), .a(k3_64), .b(m_r6.val), .res(m_k3));
   ldm_delay #(.DEPTH(ldm_pkg::MUL_LAT - 1), .WIDTH(64)) u_dly_rad2 (
      .clock, .enable(en), .din(s_rad2_ff.val), .dout(rad2_d4));

   // ---------------------------------------------------------------- combine (t22..t29)
   logic [63:0]       x_d22, y_d22, tx1d_d16, ty1_d15, tx2_d16, ty2d_d17;
   ldm_pkg::qval_type m_xr, m_yr;
   ldm_pkg::qval_type s_xa_ff, s_ya_ff, s_xd_ff, s_yd_ff;

   ldm_delay #(.DEPTH(22), .WIDTH(64)) u_dly_x (
      .clock, .enable(en), .din(x0), .dout(x_d22));
   ldm_delay #(.DEPTH(22), .WIDTH(64)) u_dly_y (
      .clock, .enable(en), .din(y0), .dout(y_d22));
   ldm_mulq u_mul_xr (.clock, .enable(en), .a($signed(x_d22)), .b(s_rad_ff.val),
                      .res(m_xr));
   ldm_mulq u_mul_yr (.clock, .enable(en), .a($signed(y_d22)), .b(s_rad_ff.val),
                      .res(m_yr));
   ldm_delay #(.DEPTH(16), .WIDTH(64)) u_dly_tx1d (
      .clock, .enable(en), .din(s_tx1d_ff.val), .dout(tx1d_d16));
   ldm_delay #(.DEPTH(15), .WIDTH(64)) u_dly_ty1 (
      .clock, .enable(en), .din(m_ty1.val), .dout(ty1_d15));
   ldm_delay #(.DEPTH(16), .WIDTH(64)) u_dly_tx2 (
      .clock, .enable(en), .din(m_tx2.val), .dout(tx2_d16));
   ldm_delay #(.DEPTH(17), .WIDTH(64)) u_dly_ty2d (
      .clock, .enable(en), .din(s_ty2d_ff.val), .dout(ty2d_d17));

   // ---------------------------------------------------------------- back to pixels (t34)
   ldm_pkg::qval_type m_fx, m_fy;

   ldm_mulq u_mul_fx (.clock, .enable(en), .a(s_xd_ff.val), .b(fx64), .res(m_fx));
   ldm_mulq u_mul_fy (.clock, .enable(en), .a(s_yd_ff.val), .b(fy64), .res(m_fy));

   // clamped adds, each one register stage
   always_ff @(posedge clock) begin
      if (en) begin
         s_r2_ff   <= ldm_pkg::sat_add(m_x2.val, m_y2.val);
         s_sx_ff   <= ldm_pkg::sat_add(m_x2.val, m_x2.val);
         s_sy_ff   <= ldm_pkg::sat_add(m_y2.val, m_y2.val);
         s_tsx_ff  <= ldm_pkg::sat_add(s_r2_ff.val, s_sx_ff.val);
         s_tsy_ff  <= ldm_pkg::sat_add(s_r2_ff.val, s_sy_ff.val);
         s_tx1d_ff <= ldm_pkg::sat_add(m_tx1.val, m_tx1.val);
         s_ty2d_ff <= ldm_pkg::sat_add(m_ty2.val, m_ty2.val);
         s_rad1_ff <= ldm_pkg::sat_add(ldm_pkg::ONE_Q, m_k1.val);
         s_rad2_ff <= ldm_pkg::sat_add($signed(rad1_d4), m_k2.val);
         s_rad_ff  <= ldm_pkg::sat_add($signed(rad2_d4), m_k3.val);
         s_xa_ff   <= ldm_pkg::sat_add(m_xr.val, $signed(tx1d_d16));
         s_ya_ff   <= ldm_pkg::sat_add(m_yr.val, $signed(ty1_d15));
         s_xd_ff   <= ldm_pkg::sat_add(s_xa_ff.val, $signed(tx2_d16));
         s_yd_ff   <= ldm_pkg::sat_add(s_ya_ff.val, $signed(ty2d_d17));
      end
   end

   // ---------------------------------------------------------------- overflow tracking
   // fl[t] gathers the clamp flags of values held at stage t after the divider
   logic [34:0] fl;
   logic [34:1] ovc_ff;
   logic [33:0] ovp;

   always_comb begin
      fl     = '0;
      fl[5]  = m_x2.ov | m_y2.ov | m_xy.ov;
      fl[6]  = s_r2_ff.ov | s_sx_ff.ov | s_sy_ff.ov;
      fl[7]  = s_tsx_ff.ov | s_tsy_ff.ov;
      fl[10] = m_tx1.ov | m_ty2.ov;
      fl[11] = s_tx1d_ff.ov | s_ty2d_ff.ov | m_r4.ov | m_k1.ov;
      fl[12] = m_tx2.ov | m_ty1.ov | s_rad1_ff.ov;
      fl[16] = m_r6.ov | m_k2.ov;
      fl[17] = s_rad2_ff.ov;
      fl[21] = m_k3.ov;
      fl[22] = s_rad_ff.ov;
      fl[27] = m_xr.ov | m_yr.ov;
      fl[28] = s_xa_ff.ov | s_ya_ff.ov;
      fl[29] = s_xd_ff.ov | s_yd_ff.ov;
      fl[34] = m_fx.ov | m_fy.ov;
   end

   assign ovp = {ovc_ff[33:1], 1'b0};

   always_ff @(posedge clock) begin
      if (en) begin
         ovc_ff <= ovp | fl[33:0];
      end
   end

   // ---------------------------------------------------------------- final clamp (t35)
   logic signed [63:0] vx, vy;
   logic signed [31:0] wx_in, wy_in, wx_ff, wy_ff;
   logic               clx, cly, ov_ff;

   always_comb begin
      vx  = m_fx.val + 64'(center_x_ff);
      vy  = m_fy.val + 64'(center_y_ff);
      clx = 1'b1;
      cly = 1'b1;
      if (vx > 64'sd2147483647) begin
         wx_in = 32'sh7FFF_FFFF;
      end else if (vx < -64'sd2147483648) begin
         wx_in = 32'sh8000_0000;
      end else begin
         wx_in = vx[31:0];
         clx   = 1'b0;
      end
      if (vy > 64'sd2147483647) begin
         wy_in = 32'sh7FFF_FFFF;
      end else if (vy < -64'sd2147483648) begin
         wy_in = 32'sh8000_0000;
      end else begin
         wy_in = vy[31:0];
         cly   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= wx_in;
         wy_ff <= wy_in;
         ov_ff <= ovc_ff[34] | fl[34] | clx | cly;
      end
   end

   // ---------------------------------------------------------------- output and skid
   logic               out_vld_ff;
   logic signed [31:0] out_x_ff, out_y_ff, skid_x_ff, skid_y_ff;
   logic               out_ov_ff, skid_ov_ff;
   logic               out_take, pipe_vld;

   assign out_take = out_vld_ff && !rsp_stall;
   assign pipe_vld = vld_ff[VLEN-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         // pipeline frozen, drain the skid register first
         if (!out_vld_ff || out_take) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end
      end else if (pipe_vld) begin
         if (out_vld_ff && !out_take) begin
            skid_vld_ff <= 1'b1;
         end else begin
            out_vld_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (!out_vld_ff || out_take) begin
            out_x_ff  <= skid_x_ff;
            out_y_ff  <= skid_y_ff;
            out_ov_ff <= skid_ov_ff;
         end
      end else if (pipe_vld) begin
         if (out_vld_ff && !out_take) begin
            skid_x_ff  <= wx_ff;
            skid_y_ff  <= wy_ff;
            skid_ov_ff <= ov_ff;
         end else begin
            out_x_ff  <= wx_ff;
            out_y_ff  <= wy_ff;
            out_ov_ff <= ov_ff;
         end
      end
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_warped_x = out_x_ff;
   assign rsp_warped_y = out_y_ff;
   assign rsp_overflow = out_ov_ff;

   // ---------------------------------------------------------------- checks
   `LDM_ASSERT(a_skid_needs_out, clock, reset, skid_vld_ff, out_vld_ff)
   `LDM_ASSERT_NEXT(a_skid_catches, clock, reset,
      out_vld_ff && rsp_stall && !skid_vld_ff && pipe_vld, skid_vld_ff)
   `LDM_ASSERT_NEXT(a_out_drains, clock, reset,
      out_vld_ff && !rsp_stall && !skid_vld_ff && !pipe_vld, !out_vld_ff)

endmodule

`default_nettype wire
